FILE: hdl/fagc_pkg.sv
package fagc_pkg;

  localparam int unsigned MaxWindow = 1024;
  localparam int unsigned EnvCoef = 13107;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_REFERENCE_LEVEL = 2'd1,
    CFG_ENVELOPE_FLOOR = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_OLD_READ,
    ST_OLD_WAIT,
    ST_DIV_I,
    ST_DIV_Q,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;      // write zero at the clear address
    logic load_sample;   // capture the accepted beat
    logic write_sample;  // store the sample into the ring
    logic scan_start;    // reset running max and scan pointer
    logic scan_rd;       // issue a read for the scan
    logic scan_acc;      // fold the read data into the max
    logic old_rd;        // issue a read of the oldest sample
    logic old_cap;       // capture the oldest sample
    logic div_start_i;   // start dividing the I part
    logic div_start_q;   // start dividing the Q part
    logic out_load;      // load the output register
    logic slot_adv;      // advance the write slot
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic scan_last;
    logic div_busy;
  } stat_t;

  function automatic logic [16:0] env_of(input logic [31:0] packed_s);
    logic [16:0] a;
    logic [16:0] b;
    logic [16:0] hi;
    logic [16:0] lo;
    logic [30:0] prod;
    a = packed_s[15] ? 17'(-$signed({packed_s[15], packed_s[15:0]}))
                     : {1'b0, packed_s[15:0]};
    b = packed_s[31] ? 17'(-$signed({packed_s[31], packed_s[31:16]}))
                     : {1'b0, packed_s[31:16]};
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    prod = 31'(lo) * 31'(EnvCoef);
    return 17'(hi + 17'(prod >> 15));
  endfunction

endpackage

FILE: hdl/fagc_ram.sv
module fagc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/fagc_div.sv
// Restoring divider, signed dividend by unsigned divisor, one quotient bit per cycle.
module fagc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] num_i,
  input  logic [16:0]        den_i,
  output logic               busy_o,
  output logic signed [15:0] quo_o,
  output logic               sat_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [16:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [17:0] trial;
  logic [32:0] mag;
  logic [32:0] sq;

  assign mag = num_i[32] ? 33'(-num_i) : num_i;
  assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    neg_d = neg_q;
    if (start_i) begin
      cnt_d = 6'd32;
      quo_d = mag[31:0];
      rem_d = '0;
      den_d = den_i;
      neg_d = num_i[32];
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign sq = neg_q ? 33'(-$signed({1'b0, quo_q})) : {1'b0, quo_q};

  always_comb begin
    if (!neg_q && quo_q > 32'd32767) begin
      quo_o = 16'sd32767;
      sat_o = 1'b1;
    end else if (neg_q && quo_q > 32'd32768) begin
      quo_o = -16'sd32768;
      sat_o = 1'b1;
    end else begin
      quo_o = sq[15:0];
      sat_o = 1'b0;
    end
  end

endmodule

FILE: hdl/fagc_dp.sv
module fagc_dp #(
  parameter int unsigned MaxWin = fagc_pkg::MaxWindow
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fagc_pkg::ctrl_t     ctrl_i,
  output fagc_pkg::stat_t     stat_o,
  input  logic [15:0]         sample_i_i,
  input  logic [15:0]         sample_q_i,
  input  logic [10:0]         window_length_i,
  input  logic [15:0]         reference_level_i,
  input  logic [15:0]         envelope_floor_i,
  output logic [15:0]         out_i_o,
  output logic [15:0]         out_q_o,
  output logic                clipped_o
);

  import fagc_pkg::*;

  localparam int unsigned AddrW = (MaxWin > 1) ? $clog2(MaxWin) : 1;
  localparam int unsigned LenW = $clog2(MaxWin + 1) + 1;

  logic [AddrW-1:0] slot_q, clr_q, scan_q, scan_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [31:0]      smp_q, old_q;
  logic [16:0]      max_q, max_d, env;
  logic [15:0]      oi_q;
  logic             sat_q;
  logic [LenW-1:0]  len, wl;
  logic             we;
  logic [AddrW-1:0] waddr, raddr, oldest;
  logic [31:0]      wdata, rdata;
  logic [16:0]      floor_v;
  logic             dstart;
  logic signed [32:0] num;
  logic             dbusy, dsat;
  logic signed [15:0] dquo;

  assign wl = LenW'(window_length_i);
  always_comb begin
    len = wl;
    if (wl == '0) len = LenW'(1);
    if (wl > LenW'(MaxWin)) len = LenW'(MaxWin);
  end

  // ring index arithmetic mod MaxWin, wraps naturally only at a power of two
  function automatic logic [AddrW-1:0] sub_mod(input logic [AddrW-1:0] a,
                                               input logic [LenW-1:0] b);
    logic [LenW:0] t;
    t = (LenW+1)'(a) + (LenW+1)'(MaxWin) - (LenW+1)'(b);
    if (t >= (LenW+1)'(MaxWin)) t = t - (LenW+1)'(MaxWin);
    return AddrW'(t);
  endfunction

  function automatic logic [AddrW-1:0] inc_mod(input logic [AddrW-1:0] a);
    logic [AddrW:0] t;
    t = (AddrW+1)'(a) + (AddrW+1)'(1);
    if (t >= (AddrW+1)'(MaxWin)) t = '0;
    return AddrW'(t);
  endfunction

  assign oldest = sub_mod(slot_q, len - LenW'(1));
  assign floor_v = (envelope_floor_i == '0) ? 17'd1 : {1'b0, envelope_floor_i};
  assign env = env_of(rdata);

  always_comb begin
    we = 1'b0;
    waddr = slot_q;
    wdata = smp_q;
    if (ctrl_i.clear_wr) begin
      we = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (ctrl_i.write_sample) begin
      we = 1'b1;
    end
    raddr = ctrl_i.old_rd ? oldest : scan_q;
  end

  fagc_ram #(.Width(32), .Depth(MaxWin)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    scan_d = scan_q;
    left_d = left_q;
    max_d = max_q;
    if (ctrl_i.scan_start) begin
      scan_d = slot_q;
      left_d = len;
      max_d = floor_v;
    end else begin
      if (ctrl_i.scan_rd) begin
        scan_d = sub_mod(scan_q, LenW'(1));
        left_d = left_q - LenW'(1);
      end
      if (ctrl_i.scan_acc && env > max_q) max_d = env;
    end
  end

  assign num = ctrl_i.div_start_i
             ? 33'(signed'(old_q[15:0])) * signed'({17'd0, reference_level_i})
             : 33'(signed'(old_q[31:16])) * signed'({17'd0, reference_level_i});
  assign dstart = ctrl_i.div_start_i | ctrl_i.div_start_q;

  fagc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart),
    .num_i   (num),
    .den_i   (max_q),
    .busy_o  (dbusy),
    .quo_o   (dquo),
    .sat_o   (dsat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      clr_q  <= '0;
    end else begin
      if (ctrl_i.clear_wr) clr_q <= inc_mod(clr_q);
      if (ctrl_i.slot_adv) slot_q <= inc_mod(slot_q);
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    left_q <= left_d;
    max_q  <= max_d;
    if (ctrl_i.load_sample) smp_q <= {sample_q_i, sample_i_i};
    if (ctrl_i.old_cap) old_q <= rdata;
    // first finished quotient is I, latched when the Q division starts
    if (ctrl_i.div_start_q) begin
      oi_q  <= dquo;
      sat_q <= dsat;
    end
    if (ctrl_i.out_load) begin
      out_i_o <= oi_q;
      out_q_o <= dquo;
      clipped_o <= sat_q | dsat;
    end
  end

  assign stat_o.clear_done = (clr_q == AddrW'(MaxWin - 1));
  assign stat_o.scan_last  = (left_q == LenW'(1)) & ~ctrl_i.scan_start;
  assign stat_o.div_busy   = dbusy;

endmodule

FILE: hdl/fagc_ctrl.sv
module fagc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fagc_pkg::ctrl_t ctrl_o,
  input  fagc_pkg::stat_t stat_i
);

  import fagc_pkg::*;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   first_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:      if (stat_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:       if (in_valid_i) state_d = ST_WRITE;
      ST_WRITE:      state_d = ST_SCAN;
      ST_SCAN:       if (stat_i.scan_last) state_d = ST_SCAN_DRAIN;
      ST_SCAN_DRAIN: state_d = ST_OLD_READ;
      ST_OLD_READ:   state_d = ST_OLD_WAIT;
      ST_OLD_WAIT:   state_d = ST_DIV_I;
      ST_DIV_I:      if (!first_q && !stat_i.div_busy) state_d = ST_DIV_Q;
      ST_DIV_Q:      if (!first_q && !stat_i.div_busy) state_d = ST_OUT;
      ST_OUT:        if (!ovalid_q || out_ready_i) state_d = ST_IDLE;
      default:       state_d = ST_CLEAR;
    endcase
  end

  // DIV_I/DIV_Q: first cycle starts the unit, busy then covers the rest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ovalid_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      first_q  <= (state_d != state_q);
    end
  end

  always_comb begin
    ctrl_o = '0;
    in_ready_o = 1'b0;
    ovalid_d = ovalid_q & ~out_ready_i;
    unique case (state_q)
      ST_CLEAR: ctrl_o.clear_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctrl_o.load_sample = in_valid_i;
      end
      ST_WRITE: begin
        ctrl_o.write_sample = 1'b1;
        ctrl_o.scan_start = 1'b1;
      end
      ST_SCAN: begin
        ctrl_o.scan_rd = 1'b1;
        ctrl_o.scan_acc = !first_q;
      end
      ST_SCAN_DRAIN: ctrl_o.scan_acc = 1'b1;
      ST_OLD_READ: ctrl_o.old_rd = 1'b1;
      ST_OLD_WAIT: ctrl_o.old_cap = 1'b1;
      ST_DIV_I: ctrl_o.div_start_i = first_q;
      ST_DIV_Q: ctrl_o.div_start_q = first_q;
      ST_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.slot_adv = 1'b1;
          ovalid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = ovalid_q;

endmodule

FILE: hdl/feedforward_agc_window_max.sv
// Channel  | handshake                  | payload
// in       | in_valid_i / in_ready_o    | sample_i_i, sample_q_i
// out      | out_valid_o / out_ready_i  | out_i_o, out_q_o, clipped_o
// cfg      | cfg_we_i                   | cfg_idx_i, cfg_data_i
// One item covers window_length entries (0 counts as 1, above MaxWin as MaxWin):
// a scan of the ring RAM through its single read port, one entry per cycle, then
// two 32-step serial divisions.
// After reset a clearing pass zeroes the ring with in_ready_o low.
// The output register holds a result while the next item is already worked on;
// the result is loaded only when the previous one has been taken.
module feedforward_agc_window_max #(
  parameter int unsigned MaxWin = fagc_pkg::MaxWindow
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [15:0]                   sample_i_i,
  input  logic [15:0]                   sample_q_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [15:0]                   out_i_o,
  output logic [15:0]                   out_q_o,
  output logic                          clipped_o,
  input  logic                          cfg_we_i,
  input  logic [fagc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fagc_pkg::CfgDataW-1:0] cfg_data_i
);

  import fagc_pkg::*;

  logic [10:0] window_length_q;
  logic [15:0] reference_level_q, envelope_floor_q;
  ctrl_t ctrl;
  stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q   <= 11'd1024;
      reference_level_q <= 16'd32768;
      envelope_floor_q  <= 16'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_LENGTH:   window_length_q   <= cfg_data_i[10:0];
        CFG_REFERENCE_LEVEL: reference_level_q <= cfg_data_i;
        CFG_ENVELOPE_FLOOR:  envelope_floor_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fagc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl),
    .stat_i      (stat)
  );

  fagc_dp #(.MaxWin(MaxWin)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .sample_i_i        (sample_i_i),
    .sample_q_i        (sample_q_i),
    .window_length_i   (window_length_q),
    .reference_level_i (reference_level_q),
    .envelope_floor_i  (envelope_floor_q),
    .out_i_o           (out_i_o),
    .out_q_o           (out_q_o),
    .clipped_o         (clipped_o)
  );

endmodule

FILE: bench/feedforward_agc_window_max_tb.sv
module feedforward_agc_window_max_tb;
  import fagc_pkg::*;

  localparam int unsigned RingDepth = 1024;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned HoldCycles = 3000;

  typedef struct {
    logic [15:0] out_i;
    logic [15:0] out_q;
    logic        clipped;
  } agc_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] smp_i = '0;
  logic [15:0] smp_q = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] res_i;
  logic [15:0] res_q;
  logic res_clip;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // predictor state
  logic [31:0] ring_mem [RingDepth];
  int unsigned wr_slot;
  int unsigned win_len;
  int unsigned ref_lvl;
  int unsigned env_floor;

  agc_beat_t scaled_q[$];
  int unsigned err_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit idle_on = 1'b1;
  bit hold_rx = 1'b0;

  always #2 clk = ~clk;

  feedforward_agc_window_max DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i_i  (smp_i),
    .sample_q_i  (smp_q),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_i_o     (res_i),
    .out_q_o     (res_q),
    .clipped_o   (res_clip),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  function automatic int unsigned envelope(logic [31:0] w);
    int si;
    int sq;
    int unsigned a;
    int unsigned b;
    int unsigned hi;
    int unsigned lo;
    si = $signed(w[15:0]);
    sq = $signed(w[31:16]);
    a = (si < 0) ? -si : si;
    b = (sq < 0) ? -sq : sq;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    return hi + ((13107 * lo) >> 15);
  endfunction

  function automatic logic [15:0] apply_gain(logic [15:0] s, int unsigned div, inout bit sat);
    longint num;
    longint quo;
    num = longint'($signed(s)) * longint'(ref_lvl);
    quo = num / longint'(div);
    if (quo > 32767) begin
      sat = 1'b1;
      return 16'h7fff;
    end
    if (quo < -32768) begin
      sat = 1'b1;
      return 16'h8000;
    end
    return quo[15:0];
  endfunction

  task automatic predict_gain(logic [15:0] si, logic [15:0] sq);
    int unsigned len;
    int unsigned peak;
    int unsigned e;
    int unsigned oldest;
    bit sat;
    agc_beat_t b;
    len = (win_len == 0) ? 1 : (win_len > RingDepth ? RingDepth : win_len);
    peak = (env_floor == 0) ? 1 : env_floor;
    sat = 1'b0;
    ring_mem[wr_slot] = {sq, si};
    for (int unsigned k = 0; k < len; k++) begin
      e = envelope(ring_mem[(wr_slot + RingDepth - k) % RingDepth]);
      if (e > peak) peak = e;
    end
    oldest = (wr_slot + RingDepth - (len - 1)) % RingDepth;
    b.out_i = apply_gain(ring_mem[oldest][15:0], peak, sat);
    b.out_q = apply_gain(ring_mem[oldest][31:16], peak, sat);
    b.clipped = sat;
    scaled_q.push_back(b);
    wr_slot = (wr_slot + 1) % RingDepth;
  endtask

  // one input beat; valid stays up after accept so back-to-back beats need no toggle
  task automatic send_sample(logic [15:0] si, logic [15:0] sq);
    if (idle_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
    in_valid <= 1'b1;
    smp_i <= si;
    smp_q <= sq;
    do @(posedge clk); while (!in_ready);
    predict_gain(si, sq);
  endtask

  task automatic drain(int unsigned settle);
    in_valid <= 1'b0;
    while (scaled_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned wl, int unsigned rl, int unsigned fl);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_WINDOW_LENGTH;
    cfg_data <= 16'(wl);
    @(posedge clk);
    cfg_idx <= CFG_REFERENCE_LEVEL;
    cfg_data <= 16'(rl);
    @(posedge clk);
    cfg_idx <= CFG_ENVELOPE_FLOOR;
    cfg_data <= 16'(fl);
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len = wl & 16'h7ff;
    ref_lvl = rl & 16'hffff;
    env_floor = fl & 16'hffff;
  endtask

  task automatic send_extremes();
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'h0001, 16'hffff);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(3))
      0: return 16'($urandom_range(64)) - 16'd32;
      1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // reset values: full window, mostly zeroed history
  task automatic test_reset_defaults();
    send_extremes();
    drain(1200);
  endtask

  task automatic test_window_extremes();
    set_regs(0, 32768, 3);
    send_extremes();
    drain(100);
    set_regs(2047, 32768, 3);
    send_sample(16'h1234, 16'hedcb);
    send_sample(16'h8000, 16'h0000);
    drain(1200);
    set_regs(1, 32768, 3);
    send_sample(16'h4000, 16'hc000);
    drain(100);
  endtask

  task automatic test_floor_and_ref();
    set_regs(4, 0, 0);
    send_extremes();
    drain(100);
    set_regs(1, 65535, 1);
    send_sample(16'h0001, 16'h0000);
    send_sample(16'hffff, 16'h0002);
    send_sample(16'h0000, 16'h0000);
    drain(100);
    set_regs(2, 65535, 65535);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h0100, 16'hff00);
    drain(100);
  endtask

  // window shrinks over a ring that holds a longer history
  task automatic test_window_change();
    set_regs(8, 40000, 10);
    for (int k = 0; k < 8; k++) send_sample(rand_sample(), rand_sample());
    drain(100);
    set_regs(3, 40000, 10);
    for (int k = 0; k < 3; k++) send_sample(rand_sample(), rand_sample());
    drain(100);
  endtask

  task automatic test_backpressure();
    set_regs(4, 32768, 3);
    fork
      begin
        hold_rx = 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_rx = 1'b0;
      end
    join_none
    for (int k = 0; k < 8; k++) send_sample(rand_sample(), rand_sample());
    // sender pauses until everything is back
    drain(100);
    for (int k = 0; k < 4; k++) send_sample(rand_sample(), rand_sample());
    drain(100);
  endtask

  task automatic test_random();
    int unsigned wl;
    int unsigned rl;
    int unsigned fl;
    for (int ph = 0; ph < 15; ph++) begin
      case ($urandom_range(9))
        0: wl = 1024;
        1: wl = $urandom_range(1) ? 0 : 2047;
        default: wl = $urandom_range(1, 16);
      endcase
      rl = $urandom_range(3) == 0 ? ($urandom_range(1) ? 0 : 65535) : $urandom_range(65535);
      fl = $urandom_range(1) ? $urandom_range(0, 64) : $urandom_range(65535);
      set_regs(wl, rl, fl);
      idle_on = (ph != 7);
      for (int k = 0; k < ((wl == 1024 || wl == 2047) ? 8 : 30); k++)
        send_sample(rand_sample(), rand_sample());
      drain(wl + 100);
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    agc_beat_t want;
    if (out_valid && out_ready) begin
      if (scaled_q.size() == 0) begin
        err_cnt++;
        $display("unexpected output beat i=%h q=%h clip=%b", res_i, res_q, res_clip);
      end else begin
        want = scaled_q.pop_front();
        if (res_i !== want.out_i || res_q !== want.out_q || res_clip !== want.clipped) begin
          err_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp i=%h q=%h clip=%b got i=%h q=%h clip=%b",
                     want.out_i, want.out_q, want.clipped, res_i, res_q, res_clip);
        end
      end
    end
    if (hold_rx) out_ready <= 1'b0;
    else if (idle_on) out_ready <= ($urandom_range(99) >= 38);
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < RingDepth; k++) ring_mem[k] = '0;
    wr_slot = 0;
    win_len = 1024;
    ref_lvl = 32768;
    env_floor = 3;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_window_extremes();
    test_floor_and_ref();
    test_window_change();
    test_backpressure();
    test_random();
    drain(200);
    if (err_cnt == 0 && scaled_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/fagc_pkg.sv
hdl/fagc_ram.sv
hdl/fagc_div.sv
hdl/fagc_dp.sv
hdl/fagc_ctrl.sv
hdl/feedforward_agc_window_max.sv
bench/feedforward_agc_window_max_tb.sv
